[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed")

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed")

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed")

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/b36_pkg.sv]
// ----------------------------------------------------------------------------
// b36_pkg
// Constants, control word types, the microcode program and the character
// mapping for the base-36 number to text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b36_pkg;

    // Field widths.
    localparam int VALUE_W   = 63;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 6;

    // Default depth of the digit store; 13 digits cover every 63-bit value.
    localparam int MAX_DIGITS_DEF = 13;

    // The working register is one bit wider than the value, so the long
    // division walks it in whole bytes.
    localparam int CHUNK_W    = 8;
    localparam int WORK_W     = 64;
    localparam int NUM_CHUNKS = WORK_W / CHUNK_W;
    localparam int CHUNK_CW   = $clog2(NUM_CHUNKS);

    localparam logic [DIGIT_W:0]  RADIX     = 7'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 7'h5A;

    // Program counter and step addresses.
    localparam int PC_W = 2;
    localparam logic [PC_W-1:0] PC_LOAD  = 2'd0;
    localparam logic [PC_W-1:0] PC_DIV   = 2'd1;
    localparam logic [PC_W-1:0] PC_STORE = 2'd2;
    localparam logic [PC_W-1:0] PC_EMIT  = 2'd3;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        OP_LOAD  = 4'b0001,
        OP_DIV   = 4'b0010,
        OP_STORE = 4'b0100,
        OP_EMIT  = 4'b1000
    } t_op;

    // Jump condition; when it is false the sequencer falls through.
    typedef enum logic [1:0] {
        COND_WAIT        = 2'd0,
        COND_CHUNK_MORE  = 2'd1,
        COND_MORE_DIGITS = 2'd2,
        COND_EMIT_MORE   = 2'd3
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Microcode program.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_WAIT,        target: PC_LOAD};
            PC_DIV:   w = '{op: OP_DIV,   cond: COND_CHUNK_MORE,  target: PC_DIV};
            PC_STORE: w = '{op: OP_STORE, cond: COND_MORE_DIGITS, target: PC_DIV};
            PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_MORE,   target: PC_EMIT};
        endcase
        return w;
    endfunction

    // Map a digit of 0 to 35 onto '0'-'9' or 'A'-'Z'.
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/base36_number_to_text.sv]
// ----------------------------------------------------------------------------
// base36_number_to_text
// Renders a 63-bit unsigned value as uppercase base-36 ASCII text, most
// significant character first, with no leading zeros; zero gives "0" and the
// final character carries o_is_last. One word in is taken when the converter
// is waiting for input. Each base-36 digit takes eight long division steps of
// one byte each through a single divide-by-36 unit, then a step that stores
// the remainder. Each character then leaves through an output register, which
// holds it while the output stalls. The next word is accepted while the final
// character still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module base36_number_to_text #(
    parameter int MAX_DIGITS = b36_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [b36_pkg::VALUE_W-1:0]  i_value,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [b36_pkg::CHAR_W-1:0]        o_out_char,
    output logic                              o_is_last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [b36_pkg::CHUNK_CW-1:0] CHUNK_LAST =
        b36_pkg::CHUNK_CW'(b36_pkg::NUM_CHUNKS - 1);

    // Control state.
    logic [b36_pkg::PC_W-1:0]     r_pc,        n_pc;
    logic [b36_pkg::CHUNK_CW-1:0] r_chunk,     n_chunk;
    logic [CNT_W-1:0]             r_count,     n_count;
    logic                         r_out_valid, n_out_valid;

    // Datapath.
    logic [b36_pkg::WORK_W-1:0]  r_work,     n_work;
    logic [b36_pkg::DIGIT_W-1:0] r_rem,      n_rem;
    logic [b36_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic                        r_out_last, n_out_last;
    logic [b36_pkg::DIGIT_W-1:0] r_digits [MAX_DIGITS];

    b36_pkg::t_uword             uw;
    logic                        in_fire;
    logic                        emit_fire;
    logic                        out_taken;
    logic                        jump;
    logic [CNT_W-1:0]            count_inc;
    logic [CNT_W-1:0]            count_dec;
    logic [IDX_W-1:0]            emit_idx;
    logic [b36_pkg::CHUNK_W-1:0] q_byte;
    logic [b36_pkg::DIGIT_W-1:0] div_rem;

    // Divide-by-36 unit: one byte of restoring long division per cycle.
    always_comb begin
        logic [b36_pkg::DIGIT_W:0]   trial;
        logic [b36_pkg::DIGIT_W-1:0] rem;
        rem    = r_rem;
        q_byte = '0;
        for (int b = b36_pkg::CHUNK_W - 1; b >= 0; b--) begin
            trial = {rem, r_work[b36_pkg::WORK_W - b36_pkg::CHUNK_W + b]};
            if (trial >= b36_pkg::RADIX) begin
                q_byte[b] = 1'b1;
                rem       = b36_pkg::DIGIT_W'(trial - b36_pkg::RADIX);
            end else begin
                rem = trial[b36_pkg::DIGIT_W-1:0];
            end
        end
        div_rem = rem;
    end

    // Sequencer and datapath control.
    always_comb begin
        uw        = b36_pkg::ucode(r_pc);
        in_fire   = i_in_valid && (uw.op == b36_pkg::OP_LOAD);
        emit_fire = (uw.op == b36_pkg::OP_EMIT) && (!r_out_valid || !i_out_stall);
        out_taken = r_out_valid && !i_out_stall;
        count_inc = r_count + CNT_W'(1);
        count_dec = r_count - CNT_W'(1);
        emit_idx  = count_dec[IDX_W-1:0];

        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_count     = r_count;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (uw.op)
            b36_pkg::OP_LOAD: begin
                if (in_fire) begin
                    n_work  = {1'b0, i_value};
                    n_rem   = '0;
                    n_chunk = '0;
                    n_count = '0;
                end
            end
            b36_pkg::OP_DIV: begin
                n_work  = {r_work[b36_pkg::WORK_W-b36_pkg::CHUNK_W-1:0], q_byte};
                n_rem   = div_rem;
                n_chunk = r_chunk + b36_pkg::CHUNK_CW'(1);
            end
            b36_pkg::OP_STORE: begin
                n_count = count_inc;
                n_rem   = '0;
            end
            b36_pkg::OP_EMIT: begin
                if (emit_fire) begin
                    n_count    = count_dec;
                    n_out_char = b36_pkg::glyph(r_digits[emit_idx]);
                    n_out_last = (r_count == CNT_W'(1));
                end
            end
            default: begin
            end
        endcase

        // The output register fills on an emit and empties when taken.
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        // Conditional jump or fall through to the next step.
        unique case (uw.cond)
            b36_pkg::COND_WAIT:        jump = !in_fire;
            b36_pkg::COND_CHUNK_MORE:  jump = (r_chunk != CHUNK_LAST);
            b36_pkg::COND_MORE_DIGITS: jump = (r_work != '0) &&
                                              (count_inc < CNT_W'(MAX_DIGITS));
            b36_pkg::COND_EMIT_MORE:   jump = !(emit_fire && (r_count == CNT_W'(1)));
            default:                   jump = 1'b0;
        endcase
        n_pc = jump ? uw.target : r_pc + b36_pkg::PC_W'(1);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= b36_pkg::PC_LOAD;
            r_chunk     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Digit store, written once per digit in the store step.
    always_ff @(posedge i_clk) begin
        if (uw.op == b36_pkg::OP_STORE) begin
            r_digits[r_count[IDX_W-1:0]] <= r_rem;
        end
    end

    assign o_in_stall  = (uw.op != b36_pkg::OP_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_is_last   = r_out_last;

    // Checks.
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_DIGITS));
    `ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_pc == b36_pkg::PC_DIV);
    `ASSERT_IMPLIES(a_emit_has_digit, i_clk, i_rst_n, r_pc == b36_pkg::PC_EMIT, r_count != '0);
    `ASSERT_NEXT(a_last_returns, i_clk, i_rst_n, emit_fire && (r_count == CNT_W'(1)), r_pc == b36_pkg::PC_LOAD);
    `ASSERT_IMPLIES(a_char_legal, i_clk, i_rst_n, o_out_valid, ((o_out_char >= b36_pkg::CHAR_ZERO) && (o_out_char <= b36_pkg::CHAR_NINE)) || ((o_out_char >= b36_pkg::CHAR_A) && (o_out_char <= b36_pkg::CHAR_Z)));

endmodule

`default_nettype wire
